// File: rtl/core/swm_pkg.sv
package swm_pkg;

	// default build of the filter
	localparam int MAX_WINDOW_DEF   = 64;
	localparam int SAMPLE_WIDTH_DEF = 32;

	// fixed port widths
	localparam int CFG_WIDTH = 7;
	localparam int IN_WIDTH  = 32;
	localparam int OUT_WIDTH = 33;

	// window size after reset
	localparam logic [CFG_WIDTH-1:0] WINDOW_RESET = 7'd3;

	// per-cycle control broadcast to every cell of the sorted chain
	typedef struct packed {
		logic load;   // an item is taken this cycle
		logic full;   // window already full, oldest value leaves
	} cell_ctrl_t;

endpackage

// File: rtl/core/swm_cell.sv
module swm_cell #(
	parameter int SW  = swm_pkg::SAMPLE_WIDTH_DEF,
	parameter int AW  = 6,
	parameter int CW  = 7,
	parameter int IDX = 0
) (
	input  logic                   clk,
	input  swm_pkg::cell_ctrl_t    ctrl,
	input  logic [CW-1:0]          count,
	input  logic [AW-1:0]          oldest,
	input  logic signed [SW-1:0]   smp,
	input  logic signed [SW-1:0]   prev_val,
	input  logic [AW-1:0]          prev_age,
	input  logic signed [SW-1:0]   next_val,
	input  logic [AW-1:0]          next_age,
	input  logic                   next_above,
	input  logic                   gone_in,
	input  logic                   ins_in,
	output logic                   above,
	output logic                   gone_out,
	output logic                   ins_out,
	output logic signed [SW-1:0]   val,
	output logic [AW-1:0]          age
);

	logic signed [SW-1:0] val_q;
	logic [AW-1:0]        age_q;
	logic                 here;
	logic signed [SW-1:0] up_val;
	logic [AW-1:0]        up_age;
	logic signed [SW-1:0] low_val;
	logic [AW-1:0]        low_age;

	// cell holds a live value only below the fill count
	assign here  = CW'(IDX) < count;
	// empty cells act as plus infinity
	assign above = !here | (val_q > smp);

	// deletion point: everything at or above it moves down one slot
	assign gone_out = gone_in | (ctrl.full & here & (age_q == oldest));

	// view of the chain after the delete
	assign up_val  = gone_out ? next_val : val_q;
	assign up_age  = gone_out ? next_age : age_q;
	assign low_val = gone_in ? val_q : prev_val;
	assign low_age = gone_in ? age_q : prev_age;

	// insert goes after all equal values
	assign ins_out = gone_out ? next_above : above;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			if (ins_out & !ins_in) begin
				val_q <= smp;
				age_q <= '0;
			end else if (ins_in) begin
				val_q <= low_val;
				age_q <= low_age + AW'(1);
			end else begin
				val_q <= up_val;
				age_q <= up_age + AW'(1);
			end
		end
	end

	assign val = val_q;
	assign age = age_q;

endmodule

// File: rtl/core/sliding_window_median_top.sv
// Sliding-window median filter. Signed samples enter on the in_valid/in_ready channel, one per
// clock unless stalled; the block keeps the last window_size samples in a row of MAX_WINDOW
// sorted cells, each cell holding one value and its age, so that removing the oldest sample and
// inserting the new one happens in the same cycle the item is taken. Once the window is full,
// every item yields one result, median_times_two: twice the median for an odd window, the exact
// sum of the two middle values for an even one. The first window_size-1 items of a sequence give
// no result, and a sequence shorter than the window gives none at all. last_sample ends a
// sequence: its result (if any) carries last_median, and the next item starts a fresh window.
// Throughput is one item per clock unless stalled, set by the delete-and-insert step of the cell
// row; the input stalls only when a result still waits in the median stage while the output
// register is blocked. The user must write window_size through cfg_wr_en/cfg_wr_data only while
// the block is idle; the block does not enforce this. A write drops the current sequence. Zero
// is taken as 1 and values above MAX_WINDOW as MAX_WINDOW. Reset sets window_size to 3.
module sliding_window_median_top #(
	parameter int MAX_WINDOW   = swm_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  cfg_wr_en,
	input  logic [swm_pkg::CFG_WIDTH-1:0]         cfg_wr_data,
	// input items
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [swm_pkg::IN_WIDTH-1:0]   sample,
	input  logic                                  last_sample,
	// result items
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [swm_pkg::OUT_WIDTH-1:0]  median_times_two,
	output logic                                  last_median
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int OW = swm_pkg::OUT_WIDTH;

	// configuration and fill tracking
	logic [swm_pkg::CFG_WIDTH-1:0] window_q;
	logic [CW-1:0]                 win_eff;
	logic [CW-1:0]                 fill_q;
	logic [CW-1:0]                 filled;
	logic [AW-1:0]                 oldest;
	logic                          full;
	logic                          accept;
	swm_pkg::cell_ctrl_t           ctrl;
	logic signed [SW-1:0]          smp;

	// median stage and output register
	logic                          pend_s1;
	logic                          plast_s1;
	logic                          out_valid_q;
	logic                          out_last_q;
	logic signed [OW-1:0]          median_q;
	logic                          out_free;
	logic [AW-1:0]                 lo_idx;
	logic [AW-1:0]                 hi_idx;
	logic signed [SW:0]            mid_sum;

	// cell row
	logic signed [SW-1:0] val   [MAX_WINDOW];
	logic [AW-1:0]        age   [MAX_WINDOW];
	logic                 above [MAX_WINDOW];
	logic                 gone  [MAX_WINDOW];
	logic                 ins   [MAX_WINDOW];

	// clamp the programmed size into 1..MAX_WINDOW
	always_comb begin
		if (window_q == '0) begin
			win_eff = CW'(1);
		end else if (int'(window_q) > MAX_WINDOW) begin
			win_eff = CW'(MAX_WINDOW);
		end else begin
			win_eff = CW'(window_q);
		end
	end

	assign full   = fill_q == win_eff;
	// count after this item lands
	assign filled = full ? fill_q : fill_q + CW'(1);
	// the sample about to leave has age window-1
	assign oldest = AW'(win_eff - CW'(1));
	assign smp    = sample[SW-1:0];

	assign out_free = !out_valid_q | out_ready;
	// only a result stuck behind a blocked output holds the input
	assign in_ready = !pend_s1 | out_free;
	assign accept   = in_valid & in_ready;

	assign ctrl.load = accept;
	assign ctrl.full = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= swm_pkg::WINDOW_RESET;
			fill_q   <= '0;
		end else if (cfg_wr_en) begin
			window_q <= cfg_wr_data;
			fill_q   <= '0;
		end else if (accept) begin
			fill_q <= last_sample ? '0 : filled;
		end
	end

	// sorted chain: each cell talks only to its two neighbors
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		localparam int PI = (i == 0) ? 0 : i - 1;
		localparam int NI = (i == MAX_WINDOW - 1) ? i : i + 1;

		swm_cell #(
			.SW  (SW),
			.AW  (AW),
			.CW  (CW),
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.count      (fill_q),
			.oldest     (oldest),
			.smp        (smp),
			.prev_val   (val[PI]),
			.prev_age   (age[PI]),
			.next_val   (val[NI]),
			.next_age   (age[NI]),
			// past the end of the row everything counts as larger
			.next_above ((i == MAX_WINDOW - 1) | above[NI]),
			.gone_in    ((i != 0) & gone[PI]),
			.ins_in     ((i != 0) & ins[PI]),
			.above      (above[i]),
			.gone_out   (gone[i]),
			.ins_out    (ins[i]),
			.val        (val[i]),
			.age        (age[i])
		);
	end

	// result pending: the row now holds the window this item closed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (accept) begin
			pend_s1 <= filled == win_eff;
		end else if (out_free) begin
			pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			plast_s1 <= last_sample;
		end
	end

	// middle pair: same cell twice for an odd window
	assign lo_idx  = AW'((win_eff - CW'(1)) >> 1);
	assign hi_idx  = AW'(win_eff >> 1);
	assign mid_sum = {val[lo_idx][SW-1], val[lo_idx]} + {val[hi_idx][SW-1], val[hi_idx]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_s1 & out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1 & out_free) begin
			median_q   <= OW'(mid_sum);
			out_last_q <= plast_s1;
		end
	end

	assign out_valid        = out_valid_q;
	assign median_times_two = median_q;
	assign last_median      = out_last_q;

endmodule

// File: rtl/core/swm_checker.sv
module swm_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [swm_pkg::OUT_WIDTH-1:0]  median_times_two,
	input logic                                  last_median
);

	// a blocked result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(median_times_two)
			&& $stable(last_median))
		else $error("result changed while stalled");

	// input only stalls behind a blocked output
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with output free");

	// a fresh result follows an accepted item, via the median stage and the output register
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a preceding item");

endmodule

bind sliding_window_median_top swm_checker u_swm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.median_times_two (median_times_two),
	.last_median      (last_median)
);
